// File: src/bsr_pkg.sv
// ----------------------------------------------------------------------------
// bsr_pkg: shared types and constants of the byte stream reassembly receiver
// Ring geometry, result kinds and sequencer states.
// ----------------------------------------------------------------------------
package bsr_pkg;

  localparam int WINDOW_BYTES = 4096;
  localparam int MAX_READ     = 32;
  localparam int MAX_PAYLOAD  = 2048;
  localparam int RING_AW      = $clog2(WINDOW_BYTES);
  localparam logic [32:0] SEQ_MAX = 33'h0_FFFF_FFFE;

  localparam logic [1:0] KIND_ACK   = 2'd0;
  localparam logic [1:0] KIND_DATA  = 2'd1;
  localparam logic [1:0] KIND_EMPTY = 2'd2;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_ADV_RD,
    ST_ADV_CHK,
    ST_ACK,
    ST_RD_REQ,
    ST_RD_OUT,
    ST_EMPTY
  } bsr_state_t;

endpackage

// File: src/byte_stream_reassembly_receiver.sv
// ----------------------------------------------------------------------------
// byte_stream_reassembly_receiver: selective-repeat reorder buffer
// Stores payload bytes in a ring, advances the in-order base, serves reads.
// ----------------------------------------------------------------------------
// channel | dir | tdata fields (low bit up)                          | tuser
// in_     | in  | seq_start, byte_offset, byte_value, read_count     | action
// out_    | out | ack_number, read_byte, data_ready, packet_dropped  | kind
// A payload byte that is not last is one ring write. A last byte is written,
// then the base advances over each valid entry and the ack is loaded. A read
// fetches each byte from the ring, then loads it as a result; an empty read
// gives one empty result. Every result holds off the input until it is taken.
// Reset is synchronous; a clearing pass over all 4096 ring entries follows
// it, with the input held off. A stalled output holds the sequencer.
module byte_stream_reassembly_receiver
  import bsr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [31:0] seq_start, [42:32] byte_offset, [50:43] byte_value,
  // [56:51] read_count, [63:57] zero
  input  logic [63:0] in_tdata,
  input  logic        in_tuser,  // action
  input  logic        in_tlast,  // last_of_packet
  output logic        out_tvalid,
  input  logic        out_tready,
  // [31:0] ack_number, [39:32] read_byte, [40] data_ready,
  // [41] packet_dropped, [47:42] zero
  output logic [47:0] out_tdata,
  output logic [1:0]  out_tuser, // kind
  output logic        out_tlast  // last_result
);

  // each entry holds {valid, byte}
  logic [8:0]  ring_mem [WINDOW_BYTES];
  logic [8:0]  rd_q;
  logic [RING_AW-1:0] raddr, waddr, clr_r, clr_nxt;
  logic [8:0]  wdata;
  logic        we;
  logic [31:0] base_r, base_nxt, rp_r, rp_nxt;
  logic        drop_r, drop_nxt, acc_r, acc_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  bsr_state_t  st_r, st_nxt;
  logic        ov_r, ov_nxt, ol_r, ol_nxt, ordy_r, ordy_nxt, odrp_r, odrp_nxt;
  logic [1:0]  okind_r, okind_nxt;
  logic [31:0] oack_r, oack_nxt;
  logic [7:0]  obyte_r, obyte_nxt;
  logic        wr_en;

  wire [31:0] seq   = in_tdata[31:0];
  wire [10:0] off   = in_tdata[42:32];
  wire [7:0]  bval  = in_tdata[50:43];
  wire [5:0]  rcnt  = in_tdata[56:51];
  wire [32:0] pos   = {1'b0, seq} + {22'd0, off};
  wire [32:0] limit = {1'b0, rp_r} + 33'(WINDOW_BYTES);
  wire        in_acc = in_tvalid && in_tready;
  wire        stale  = seq < base_r;
  wire        bad    = ({1'b0, off} >= 12'(MAX_PAYLOAD)) || (pos > SEQ_MAX) ||
                       (pos >= limit);
  wire        out_free = !ov_r || out_tready;
  wire        adv_go = ({1'b0, base_r} < limit) && ({1'b0, base_r} <= SEQ_MAX) &&
                       rd_q[8];
  wire        rd_last = (cnt_r == 6'd1) || (rp_r + 32'd1 >= base_r);

  assign in_tready = (st_r == ST_IDLE) && !ov_r;
  assign wr_en = in_acc && !in_tuser && !stale && !bad;

  always_ff @(posedge clk) begin
    if (we) ring_mem[waddr] <= wdata;
    rd_q <= ring_mem[raddr];
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_CLR: if (clr_r == RING_AW'(WINDOW_BYTES - 1)) st_nxt = ST_IDLE;
      ST_IDLE: if (in_acc) begin
        if (in_tuser) st_nxt = ST_RD_REQ;
        else if (in_tlast) st_nxt = ST_ADV_RD;
      end
      ST_ADV_RD: st_nxt = ST_ADV_CHK;
      ST_ADV_CHK: if (!adv_go) st_nxt = ST_ACK;
      ST_ACK: if (out_free) st_nxt = ST_IDLE;
      ST_RD_REQ: begin
        if (cnt_r == 6'd0 || rp_r >= base_r) st_nxt = ST_EMPTY;
        else st_nxt = ST_RD_OUT;
      end
      ST_RD_OUT: if (out_free) st_nxt = rd_last ? ST_IDLE : ST_RD_REQ;
      ST_EMPTY: if (out_free) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    base_nxt = base_r; rp_nxt = rp_r; clr_nxt = clr_r;
    drop_nxt = drop_r; acc_nxt = acc_r; cnt_nxt = cnt_r;
    ov_nxt = ov_r && !out_tready; ol_nxt = ol_r; ordy_nxt = ordy_r;
    odrp_nxt = odrp_r; okind_nxt = okind_r; oack_nxt = oack_r; obyte_nxt = obyte_r;
    raddr = rp_r[RING_AW-1:0];
    we = 1'b0; waddr = pos[RING_AW-1:0]; wdata = {1'b1, bval};
    unique case (st_r)
      ST_CLR: begin
        we = 1'b1; waddr = clr_r; wdata = '0;
        clr_nxt = clr_r + 1'b1;
      end
      ST_IDLE: begin
        we = wr_en;
        if (in_acc) begin
          if (in_tuser) begin
            cnt_nxt = (rcnt > 6'(MAX_READ)) ? 6'(MAX_READ) : rcnt;
          end else begin
            acc_nxt = !stale;
            if (!stale && bad) drop_nxt = 1'b1;
          end
        end
      end
      ST_ADV_RD: raddr = base_r[RING_AW-1:0];
      ST_ADV_CHK: begin
        // fetch the next entry while this one is checked
        raddr = base_r[RING_AW-1:0] + 1'b1;
        if (adv_go) base_nxt = base_r + 32'd1;
      end
      ST_ACK: if (out_free) begin
        ov_nxt = 1'b1; okind_nxt = KIND_ACK; oack_nxt = base_r;
        ordy_nxt = acc_r && (rp_r != base_r); odrp_nxt = drop_r;
        obyte_nxt = 8'd0; ol_nxt = 1'b1; drop_nxt = 1'b0;
      end
      ST_RD_REQ: ;
      ST_RD_OUT: if (out_free) begin
        ov_nxt = 1'b1; okind_nxt = KIND_DATA; oack_nxt = base_r;
        ordy_nxt = 1'b0; odrp_nxt = 1'b0; obyte_nxt = rd_q[7:0];
        we = 1'b1; waddr = rp_r[RING_AW-1:0]; wdata = '0;
        rp_nxt = rp_r + 32'd1;
        cnt_nxt = cnt_r - 6'd1;
        ol_nxt = rd_last;
      end
      ST_EMPTY: if (out_free) begin
        ov_nxt = 1'b1; okind_nxt = KIND_EMPTY; oack_nxt = base_r;
        ordy_nxt = 1'b0; odrp_nxt = 1'b0; obyte_nxt = 8'd0; ol_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_CLR; clr_r <= '0; base_r <= '0; rp_r <= '0;
      drop_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt; clr_r <= clr_nxt; base_r <= base_nxt; rp_r <= rp_nxt;
      drop_r <= drop_nxt; ov_r <= ov_nxt;
    end
    acc_r <= acc_nxt; cnt_r <= cnt_nxt; ol_r <= ol_nxt; ordy_r <= ordy_nxt;
    odrp_r <= odrp_nxt; okind_r <= okind_nxt; oack_r <= oack_nxt;
    obyte_r <= obyte_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tuser  = okind_r;
  assign out_tlast  = ol_r;
  assign out_tdata  = {6'd0, odrp_r, ordy_r, obyte_r, oack_r};

endmodule

// File: src/bsr_checker.sv
// ----------------------------------------------------------------------------
// bsr_checker: port-level checks of the byte stream reassembly receiver
// Watches handshakes and result fields at the top level.
// ----------------------------------------------------------------------------
module bsr_checker
  import bsr_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == KIND_ACK || out_tuser == KIND_DATA ||
                    out_tuser == KIND_EMPTY))
    else $error("bad result kind");

  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_ACK || out_tuser == KIND_EMPTY) |-> out_tlast)
    else $error("single result not marked last");

  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != KIND_ACK |-> out_tdata[41:40] == 2'b00)
    else $error("ack flags on non-ack result");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input taken while result pending");

endmodule

bind byte_stream_reassembly_receiver bsr_checker u_bsr_checker (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tuser(out_tuser), .out_tlast(out_tlast)
);
